// ===== rtl/lrdg_pkg.sv =====
// shared types, constants and helpers for the linear resample, downmix and gain block
package lrdg_pkg;

  localparam int unsigned MaxInChannels  = 8;
  localparam int unsigned MaxOutChannels = 4;
  localparam int unsigned MaxResults     = 32;
  localparam int unsigned CountBits      = 24;
  localparam int unsigned RateBits       = 18;
  localparam int unsigned SumBits        = 20;
  localparam int unsigned PosBits        = CountBits + 2;
  localparam int unsigned DivNumBits     = 56;
  localparam int unsigned DivDenBits     = 30;
  localparam int unsigned MagBits        = 38;
  localparam int unsigned MagHalf        = 19;
  localparam int unsigned GainBits       = 16;
  localparam int unsigned CapBits        = 6;

  typedef enum logic [2:0] {
    REG_IN_RATE      = 3'd0,
    REG_OUT_RATE     = 3'd1,
    REG_IN_CHANNELS  = 3'd2,
    REG_OUT_CHANNELS = 3'd3,
    REG_VOLUME_GAIN  = 3'd4,
    REG_FRAME_COUNT  = 3'd5
  } reg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT,
    ST_TOT_WAIT,
    ST_FRAME,
    ST_COND,
    ST_MUL,
    ST_MAG,
    ST_PP,
    ST_VDIV,
    ST_VDIV_WAIT,
    ST_PDIV,
    ST_PDIV_WAIT,
    ST_CONT,
    ST_EMIT,
    ST_END
  } state_e;

  typedef struct packed {
    logic take;
    logic tot_start;
    logic tot_load;
    logic frame_load;
    logic mul;
    logic mag;
    logic pp;
    logic vdiv_start;
    logic v_load;
    logic pdiv_start;
    logic pos_load;
    logic cont_load;
    logic emit_adv;
    logic end_frame;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic frame_done;
    logic cont;
    logic cont_q;
    logic div_done;
    logic last_ch;
  } status_t;

  // output frames allowed per input frame for a given copy count
  function automatic logic [CapBits-1:0] frame_cap(input logic [2:0] oc);
    logic [CapBits-1:0] c;
    begin
      unique case (oc)
        3'd1:    c = 6'd32;
        3'd2:    c = 6'd16;
        3'd3:    c = 6'd10;
        default: c = 6'd8;
      endcase
      return c;
    end
  endfunction

endpackage

// ===== rtl/lrdg_div.sv =====
// restoring divider, one quotient bit per cycle
module lrdg_div
  import lrdg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DivNumBits-1:0] dividend_i,
  input  logic [DivDenBits-1:0] divisor_i,
  output logic                  done_o,
  output logic [DivNumBits-1:0] quot_o,
  output logic [DivDenBits-1:0] rem_o
);

  logic                  busy_q, busy_d, done_q, done_d;
  logic [5:0]            cnt_q, cnt_d;
  logic [DivNumBits-1:0] dvd_q, dvd_d;
  logic [DivDenBits-1:0] dsr_q, dsr_d;
  logic [DivDenBits-1:0] rem_q, rem_d;
  logic [DivDenBits:0]   trial;
  logic [DivDenBits:0]   diff;

  always_comb begin
    trial  = {rem_q, dvd_q[DivNumBits-1]};
    diff   = trial - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[DivDenBits-1:0];
        dvd_d = {dvd_q[DivNumBits-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDenBits-1:0];
        dvd_d = {dvd_q[DivNumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DivNumBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/lrdg_dp.sv =====
// datapath: configuration, stream state, multipliers and shared divider
module lrdg_dp
  import lrdg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [CountBits-1:0] cfg_data_i,
  input  logic signed [15:0] sample_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic signed [15:0] out_sample_o,
  output logic [1:0]         out_channel_o,
  output logic               run_last_o,
  output logic               stream_end_o
);

  localparam logic [PosBits-1:0] PosCap = PosBits'(1) << (PosBits - 1);

  logic [RateBits-1:0]  in_rate_q, out_rate_q;
  logic [3:0]           in_ch_q;
  logic [2:0]           out_ch_q;
  logic [GainBits-1:0]  gain_q;
  logic [CountBits-1:0] frames_q;

  logic [RateBits-1:0]  irate, orate;
  logic [CountBits-1:0] frames;
  logic [3:0]           ic;
  logic [2:0]           oc;

  logic [3:0]                  chan_q;
  logic signed [SumBits-1:0]   fsum_q, prev_q, cur_q;
  logic [CountBits-1:0]        frx_q, emitted_q, total_q;
  logic [PosBits-1:0]          pos_q;
  logic [RateBits-1:0]         prem_q;
  logic                        last_q, cont_q, neg_q;
  logic [CapBits-1:0]          nfr_q;
  logic signed [SumBits+RateBits:0] p0_q, p1_q;
  logic [DivDenBits-1:0]       den_q;
  logic [MagBits-1:0]          mag_q;
  logic [MagHalf+GainBits-1:0] pplo_q, pphi_q;
  logic signed [15:0]          v_q;
  logic [1:0]                  outch_q;

  logic signed [SumBits-1:0]         a_sel;
  logic signed [RateBits:0]          w0;
  logic signed [SumBits+RateBits+1:0] num;
  logic [SumBits+RateBits+1:0]        num_abs;
  logic [DivNumBits-1:0]             div_num;
  logic [DivDenBits-1:0]             div_den;
  logic                              div_done;
  logic [DivNumBits-1:0]             quot;
  logic [DivDenBits-1:0]             rem;
  logic [2*CountBits-1:0]            fr_mul;
  logic [CountBits-1:0]              tot_val;
  logic [PosBits:0]                  pos_sum;
  logic                              pos_lt_k;
  logic [CountBits:0]                frx_inc;

  assign irate  = (in_rate_q == '0) ? RateBits'(1) : in_rate_q;
  assign orate  = (out_rate_q == '0) ? RateBits'(1) : out_rate_q;
  assign frames = (frames_q == '0) ? CountBits'(1) : frames_q;
  assign ic     = (in_ch_q == '0) ? 4'd1 : ((in_ch_q > 4'(MaxInChannels)) ?
                  4'(MaxInChannels) : in_ch_q);
  assign oc     = (out_ch_q == '0) ? 3'd1 : ((out_ch_q > 3'(MaxOutChannels)) ?
                  3'(MaxOutChannels) : out_ch_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rate_q  <= RateBits'(48000);
      out_rate_q <= RateBits'(48000);
      in_ch_q    <= 4'd1;
      out_ch_q   <= 3'd1;
      gain_q     <= GainBits'(256);
      frames_q   <= CountBits'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IN_RATE:      in_rate_q  <= cfg_data_i[RateBits-1:0];
        REG_OUT_RATE:     out_rate_q <= cfg_data_i[RateBits-1:0];
        REG_IN_CHANNELS:  in_ch_q    <= cfg_data_i[3:0];
        REG_OUT_CHANNELS: out_ch_q   <= cfg_data_i[2:0];
        REG_VOLUME_GAIN:  gain_q     <= cfg_data_i[GainBits-1:0];
        REG_FRAME_COUNT:  frames_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared divider operand select
  assign fr_mul = (2*CountBits)'(frames) * (2*CountBits)'(orate);
  always_comb begin
    div_num = {{(DivNumBits-RateBits-1){1'b0}}, {1'b0, prem_q} + {1'b0, irate}};
    div_den = DivDenBits'(orate);
    if (cmd_i.tot_start) begin
      div_num = DivNumBits'({fr_mul, 1'b0}) + DivNumBits'(irate);
      div_den = DivDenBits'({irate, 1'b0});
    end else if (cmd_i.vdiv_start) begin
      div_num = {2'b00, pphi_q, {MagHalf{1'b0}}} + DivNumBits'(pplo_q)
              + DivNumBits'(den_q >> 1);
      div_den = den_q;
    end
  end

  lrdg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.tot_start | cmd_i.vdiv_start | cmd_i.pdiv_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    if (irate == orate) begin
      tot_val = frames;
    end else if (quot == '0) begin
      tot_val = CountBits'(1);
    end else if (quot > DivNumBits'({CountBits{1'b1}})) begin
      tot_val = {CountBits{1'b1}};
    end else begin
      tot_val = quot[CountBits-1:0];
    end
  end

  assign pos_lt_k = pos_q < PosBits'(frx_q);
  assign a_sel    = pos_lt_k ? prev_q : cur_q;
  assign w0       = $signed({1'b0, orate}) - $signed({1'b0, prem_q});
  assign num      = (SumBits+RateBits+2)'(p0_q) + (SumBits+RateBits+2)'(p1_q);
  assign num_abs  = num[SumBits+RateBits+1] ? (~num + 1'b1) : num;
  assign pos_sum  = {1'b0, pos_q} + (PosBits+1)'(quot[RateBits:0]);
  assign frx_inc  = {1'b0, frx_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q    <= '0;
      fsum_q    <= '0;
      prev_q    <= '0;
      frx_q     <= '0;
      pos_q     <= '0;
      prem_q    <= '0;
      emitted_q <= '0;
      total_q   <= '0;
      last_q    <= 1'b0;
      cont_q    <= 1'b0;
      nfr_q     <= '0;
      outch_q   <= '0;
    end else begin
      if (cmd_i.take) begin
        fsum_q <= fsum_q + SumBits'(sample_i);
        chan_q <= chan_q + 4'd1;
      end
      if (cmd_i.tot_load) total_q <= tot_val;
      if (cmd_i.frame_load) begin
        fsum_q <= '0;
        chan_q <= '0;
        last_q <= frx_inc >= {1'b0, frames};
        nfr_q  <= '0;
      end
      if (cmd_i.pos_load) begin
        pos_q     <= (pos_sum >= {1'b0, PosCap}) ? PosCap : pos_sum[PosBits-1:0];
        prem_q    <= rem[RateBits-1:0];
        emitted_q <= emitted_q + 1'b1;
        nfr_q     <= nfr_q + 1'b1;
      end
      if (cmd_i.cont_load) begin
        cont_q  <= status_o.cont;
        outch_q <= '0;
      end
      if (cmd_i.emit_adv) outch_q <= outch_q + 2'd1;
      if (cmd_i.end_frame) begin
        if (last_q) begin
          chan_q    <= '0;
          fsum_q    <= '0;
          prev_q    <= '0;
          frx_q     <= '0;
          pos_q     <= '0;
          prem_q    <= '0;
          emitted_q <= '0;
          total_q   <= '0;
        end else begin
          prev_q <= cur_q;
          frx_q  <= frx_inc[CountBits-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_load) cur_q <= fsum_q;
    if (cmd_i.mul) begin
      p0_q  <= a_sel * w0;
      p1_q  <= cur_q * $signed({1'b0, prem_q});
      den_q <= {(DivDenBits-8)'(ic * orate), 8'd0};
    end
    if (cmd_i.mag) begin
      neg_q <= num[SumBits+RateBits+1];
      mag_q <= num_abs[MagBits-1:0];
    end
    if (cmd_i.pp) begin
      pplo_q <= mag_q[MagHalf-1:0] * gain_q;
      pphi_q <= mag_q[MagBits-1:MagHalf] * gain_q;
    end
    if (cmd_i.v_load) begin
      if (neg_q) begin
        v_q <= (quot > DivNumBits'(32768)) ? 16'sh8000 : 16'(-quot[15:0]);
      end else begin
        v_q <= (quot > DivNumBits'(32767)) ? 16'sh7fff : $signed(quot[15:0]);
      end
    end
  end

  assign status_o.first      = (chan_q == '0) && (frx_q == '0);
  assign status_o.frame_done = chan_q >= ic;
  assign status_o.cont       = (emitted_q < total_q) && (nfr_q < frame_cap(oc))
                               && (pos_lt_k || last_q);
  assign status_o.cont_q     = cont_q;
  assign status_o.div_done   = div_done;
  assign status_o.last_ch    = ({1'b0, outch_q} == oc - 3'd1);

  assign out_sample_o  = v_q;
  assign out_channel_o = outch_q;
  assign run_last_o    = status_o.last_ch && !cont_q;
  assign stream_end_o  = status_o.last_ch && ((emitted_q >= total_q) || (last_q && !cont_q));

endmodule

// ===== rtl/lrdg_ctrl.sv =====
// controller state machine sequencing one input word
module lrdg_ctrl
  import lrdg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_stall_o,
  output logic    out_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = status_i.first ? ST_TOT : ST_FRAME;
        end
      end
      ST_TOT: begin
        cmd_o.tot_start = 1'b1;
        state_d         = ST_TOT_WAIT;
      end
      ST_TOT_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.tot_load = 1'b1;
          state_d        = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (status_i.frame_done) begin
          cmd_o.frame_load = 1'b1;
          state_d          = ST_COND;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_COND: state_d = status_i.cont ? ST_MUL : ST_END;
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = ST_PP;
      end
      ST_PP: begin
        cmd_o.pp = 1'b1;
        state_d  = ST_VDIV;
      end
      ST_VDIV: begin
        cmd_o.vdiv_start = 1'b1;
        state_d          = ST_VDIV_WAIT;
      end
      ST_VDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.v_load = 1'b1;
          state_d      = ST_PDIV;
        end
      end
      ST_PDIV: begin
        cmd_o.pdiv_start = 1'b1;
        state_d          = ST_PDIV_WAIT;
      end
      ST_PDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.pos_load = 1'b1;
          state_d        = ST_CONT;
        end
      end
      ST_CONT: begin
        cmd_o.cont_load = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (status_i.last_ch) begin
            state_d = status_i.cont_q ? ST_MUL : ST_END;
          end else begin
            cmd_o.emit_adv = 1'b1;
          end
        end
      end
      ST_END: begin
        cmd_o.end_frame = 1'b1;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/linear_resample_downmix_gain.sv =====
// top level of the linear resample, downmix and gain block
// Takes one interleaved sample word at a time; a word that completes an input frame
// produces the output frames due at that point, each repeated once per output channel.
// The first word of a conversion also works out the output frame total with the
// shared divider. Each output frame takes two passes of the shared divider, which
// works out its 56 quotient bits one at a time, and then puts out one output channel
// word per cycle while the output does not stall. Configuration writes are always
// ready and are meant to be made between words.
module linear_resample_downmix_gain
  import lrdg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [CountBits-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   out_sample_o,
  output logic [1:0]           out_channel_o,
  output logic                 run_last_o,
  output logic                 stream_end_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  lrdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  lrdg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_sample_o  (out_sample_o),
    .out_channel_o (out_channel_o),
    .run_last_o    (run_last_o),
    .stream_end_o  (stream_end_o)
  );

endmodule
